// ===== rtl/core/sxd_pkg.sv =====
// Shared types, constants and helper functions of the salted XOR packet deframer.
package sxd_pkg;

  // Packet layout
  localparam int unsigned HdrLen      = 32;
  localparam int unsigned BodySumFrom = 28;
  localparam int unsigned MinLen      = HdrLen + 1;

  // Register reset values
  localparam logic [7:0] HeadMagicRst = 8'h81;
  localparam logic [7:0] TailMagicRst = 8'h7e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgHeadMagic = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTailMagic = 1'b1;

  // Result kinds
  localparam logic KindBody    = 1'b0;
  localparam logic KindVerdict = 1'b1;

  // Verdict status codes
  typedef enum logic [3:0] {
    StOk        = 4'd0,
    StShort     = 4'd1,
    StHead      = 4'd2,
    StTail      = 4'd3,
    StHdrSum    = 4'd4,
    StOffset    = 4'd5,
    StOverrun   = 4'd6,
    StBodySum   = 4'd7,
    StTruncated = 4'd8
  } status_e;

  // One result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  body_byte;
    status_e     status;
    logic [31:0] route_word;
    logic [31:0] sequence_number;
    logic [7:0]  retry_count;
    logic [31:0] user_ident;
    logic [31:0] session_key;
    logic [31:0] protocol_word;
    logic [15:0] decoded_length;
  } result_t;

  // Salt picked by a byte count mod 7
  function automatic logic [7:0] salt(input logic [2:0] idx);
    logic [7:0] s;
    case (idx)
      3'd0:    s = 8'h74;
      3'd1:    s = 8'he8;
      3'd2:    s = 8'ha6;
      3'd3:    s = 8'h97;
      3'd4:    s = 8'h2e;
      3'd5:    s = 8'h3c;
      3'd6:    s = 8'h59;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // (a + b) mod 7 for residues a, b below 7
  function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

  // 17-bit value mod 7: octal digits sum to the same residue since 8 = 1 mod 7
  function automatic logic [2:0] mod7_17(input logic [16:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;
    s1 = {3'b0, v[2:0]} + {3'b0, v[5:3]} + {3'b0, v[8:6]} + {3'b0, v[11:9]}
       + {3'b0, v[14:12]} + {4'b0, v[16:15]};
    s2 = {1'b0, s1[5:3]} + {1'b0, s1[2:0]};
    s3 = {3'b0, s2[3]} + {1'b0, s2[2:0]};
    if (s3 >= 4'd7) begin
      s3 = s3 - 4'd7;
    end
    return s3[2:0];
  endfunction

endpackage

// ===== rtl/core/sxd_parser.sv =====
// Per-byte packet parser: position counter, field capture, checksums and verdict logic.
module sxd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       stream_byte_i,
  input  logic             buffer_end_i,
  input  logic [7:0]       head_magic_i,
  input  logic [7:0]       tail_magic_i,
  output logic             res_valid_o,
  output sxd_pkg::result_t res_o
);

  logic [15:0] pos_q, pos_d;
  logic [2:0]  pos7_q, pos7_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  hxor_q, hxor_d;
  logic [7:0]  bxor_q, bxor_d;
  logic [7:0]  hsum_q, hsum_d;
  logic [7:0]  bsum_q, bsum_d;
  logic [15:0] size_q, size_d;
  logic [7:0]  bstart_q, bstart_d;
  logic [16:0] stop_q, stop_d;
  logic [2:0]  stop7_q, stop7_d;
  logic [31:0] route_q, route_d;
  logic [31:0] seq_q, seq_d;
  logic [7:0]  retry_q, retry_d;
  logic [31:0] user_q, user_d;
  logic [31:0] key_q, key_d;
  logic [31:0] proto_q, proto_d;

  // Field capture and running checksums; the first byte of a packet starts from cleared state
  always_comb begin
    logic        first;
    logic [15:0] p;
    logic [2:0]  p7;
    logic [15:0] len_b;
    logic [15:0] size_b;
    logic [7:0]  bstart_b;
    logic [16:0] stop_b;
    logic [7:0]  b;
    first    = (pos_q == 16'd0);
    p        = pos_q;
    b        = stream_byte_i;
    p7       = first ? 3'd0 : pos7_q;
    len_b    = first ? 16'd0 : len_q;
    size_b   = first ? 16'd0 : size_q;
    bstart_b = first ? 8'd0 : bstart_q;
    stop_b   = first ? 17'd0 : stop_q;

    len_d    = len_b;
    hsum_d   = first ? 8'd0 : hsum_q;
    bsum_d   = first ? 8'd0 : bsum_q;
    size_d   = size_b;
    bstart_d = bstart_b;
    stop_d   = stop_b;
    stop7_d  = first ? 3'd0 : stop7_q;
    route_d  = first ? 32'd0 : route_q;
    seq_d    = first ? 32'd0 : seq_q;
    retry_d  = first ? 8'd0 : retry_q;
    user_d   = first ? 32'd0 : user_q;
    key_d    = first ? 32'd0 : key_q;
    proto_d  = first ? 32'd0 : proto_q;
    hxor_d   = first ? 8'd0 : hxor_q;
    bxor_d   = first ? 8'd0 : bxor_q;

    case (p) inside
      16'd0:            len_d   = {8'd0, b};
      16'd1:            len_d   = {len_b[7:0], b};
      16'd3:            hsum_d  = b;
      [16'd4:16'd7]:    route_d = {route_d[23:0], b};
      [16'd8:16'd11]:   seq_d   = {seq_d[23:0], b};
      16'd12:           retry_d = b;
      [16'd16:16'd19]:  user_d  = {user_d[23:0], b};
      [16'd20:16'd23]:  key_d   = {key_d[23:0], b};
      [16'd24:16'd25]:  size_d  = {size_b[7:0], b};
      16'd26: begin
        bstart_d = (b == 8'd0) ? 8'(sxd_pkg::HdrLen) : b;
        // body end = offset + size, fixed from here on
        stop_d   = {9'd0, bstart_d} + {1'b0, size_b};
      end
      16'd27: begin
        bsum_d  = b;
        // body checksum count is stop - 28, and 28 is a multiple of 7
        stop7_d = sxd_pkg::mod7_17(stop_b);
      end
      [16'd28:16'd31]:  proto_d = {proto_d[23:0], b};
      default: ;
    endcase

    // Header checksum covers byte 4 up to the byte before the tail
    if ((p >= 16'd4) && (({1'b0, p} + 17'd1) != {1'b0, len_b})) begin
      hxor_d = hxor_d ^ b;
    end
    // Body checksum covers byte 28 up to the body end
    if ((p >= 16'(sxd_pkg::BodySumFrom)) && ({1'b0, p} < stop_b)) begin
      bxor_d = bxor_d ^ b;
    end

    pos7_d = (p7 == 3'd6) ? 3'd0 : p7 + 3'd1;
  end

  // Verdict and body-byte selection
  always_comb begin
    logic             short_len;
    logic             bad_head;
    logic             last_byte;
    logic             body_hit;
    logic [2:0]       p7;
    sxd_pkg::status_e st;
    p7        = (pos_q == 16'd0) ? 3'd0 : pos7_q;
    short_len = (pos_q == 16'd1) && (len_d < 16'(sxd_pkg::MinLen));
    bad_head  = (pos_q == 16'd2) && (stream_byte_i != head_magic_i);
    last_byte = (pos_q >= 16'd2) && (({1'b0, pos_q} + 17'd1) == {1'b0, len_q});
    body_hit  = (bstart_q >= 8'(sxd_pkg::HdrLen)) && (pos_q >= {8'd0, bstart_q})
              && ({1'b0, pos_q} < stop_q);

    // Check order at the tail byte
    if (stream_byte_i != tail_magic_i) begin
      st = sxd_pkg::StTail;
    end else if ((hxor_d ^ sxd_pkg::salt(sxd_pkg::add_mod7(p7, 3'd3))) != hsum_d) begin
      st = sxd_pkg::StHdrSum;
    end else if (bstart_d < 8'(sxd_pkg::HdrLen)) begin
      st = sxd_pkg::StOffset;
    end else if (stop_d >= {1'b0, len_d}) begin
      st = sxd_pkg::StOverrun;
    end else if ((bxor_d ^ sxd_pkg::salt(stop7_d)) != bsum_d) begin
      st = sxd_pkg::StBodySum;
    end else begin
      st = sxd_pkg::StOk;
    end

    res_o                 = '0;
    res_o.kind            = sxd_pkg::KindVerdict;
    res_o.route_word      = route_d;
    res_o.sequence_number = seq_d;
    res_o.retry_count     = retry_d;
    res_o.user_ident      = user_d;
    res_o.session_key     = key_d;
    res_o.protocol_word   = proto_d;
    res_o.decoded_length  = len_d;
    res_valid_o           = 1'b1;
    pos_d                 = 16'd0;

    if (short_len) begin
      res_o.status = sxd_pkg::StShort;
    end else if (bad_head) begin
      res_o.status = sxd_pkg::StHead;
    end else if (last_byte) begin
      res_o.status = st;
    end else if (buffer_end_i) begin
      res_o.status = sxd_pkg::StTruncated;
    end else begin
      pos_d = pos_q + 16'd1;
      res_o = '0;
      if (body_hit) begin
        res_o.kind      = sxd_pkg::KindBody;
        res_o.body_byte = stream_byte_i;
      end else begin
        res_valid_o = 1'b0;
      end
    end
  end

  // Position counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 16'd0;
    end else if (accept_i) begin
      pos_q <= pos_d;
    end
  end

  // Packet state; the first byte of each packet also clears it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos7_q   <= 3'd0;
      len_q    <= 16'd0;
      hxor_q   <= 8'd0;
      bxor_q   <= 8'd0;
      hsum_q   <= 8'd0;
      bsum_q   <= 8'd0;
      size_q   <= 16'd0;
      bstart_q <= 8'd0;
      stop_q   <= 17'd0;
      stop7_q  <= 3'd0;
      route_q  <= 32'd0;
      seq_q    <= 32'd0;
      retry_q  <= 8'd0;
      user_q   <= 32'd0;
      key_q    <= 32'd0;
      proto_q  <= 32'd0;
    end else if (accept_i) begin
      pos7_q   <= pos7_d;
      len_q    <= len_d;
      hxor_q   <= hxor_d;
      bxor_q   <= bxor_d;
      hsum_q   <= hsum_d;
      bsum_q   <= bsum_d;
      size_q   <= size_d;
      bstart_q <= bstart_d;
      stop_q   <= stop_d;
      stop7_q  <= stop7_d;
      route_q  <= route_d;
      seq_q    <= seq_d;
      retry_q  <= retry_d;
      user_q   <= user_d;
      key_q    <= key_d;
      proto_q  <= proto_d;
    end
  end

endmodule

// ===== rtl/core/sxd_out_reg.sv =====
// Result register between the parser and the output channel.
module sxd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             res_valid_i,
  input  sxd_pkg::result_t res_i,
  input  logic             out_stall_i,
  output logic             free_o,
  output logic             out_valid_o,
  output sxd_pkg::result_t out_o
);

  logic             valid_q, valid_d;
  sxd_pkg::result_t data_q;

  // Room for a new result when empty or when the held one leaves this cycle
  assign free_o = !valid_q || !out_stall_i;

  // Valid flag
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = res_valid_i;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

// ===== rtl/core/salted_xor_packet_deframer_top.sv =====
// Top level of the salted XOR packet deframer: config registers, parser and result register.
//
// Takes one byte per cycle and splits it into big-endian packets with a 32-byte header, a body
// and a tail magic byte. Every accepted byte is parsed in the cycle it is taken; a body byte or
// a packet verdict (with the captured header fields) appears in the result register on the next
// cycle. One byte is accepted every cycle, limited only by the result register: input stalls
// only while a result is held and the output side stalls. The head and tail magic registers are
// written through the config port, index 0 and 1; cfg_ready_o is always high.
module salted_xor_packet_deframer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sxd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  // byte input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    stream_byte_i,
  input  logic                          buffer_end_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          result_kind_o,
  output logic [7:0]                    body_byte_o,
  output logic [3:0]                    status_o,
  output logic [31:0]                   route_word_o,
  output logic [31:0]                   sequence_number_o,
  output logic [7:0]                    retry_count_o,
  output logic [31:0]                   user_ident_o,
  output logic [31:0]                   session_key_o,
  output logic [31:0]                   protocol_word_o,
  output logic [15:0]                   decoded_length_o
);

  logic [7:0]       head_magic_q;
  logic [7:0]       tail_magic_q;
  logic             free;
  logic             accept;
  logic             res_valid;
  sxd_pkg::result_t res;
  sxd_pkg::result_t out;

  // Config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_magic_q <= sxd_pkg::HeadMagicRst;
      tail_magic_q <= sxd_pkg::TailMagicRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sxd_pkg::CfgHeadMagic: head_magic_q <= cfg_data_i;
        sxd_pkg::CfgTailMagic: tail_magic_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input transaction
  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  sxd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .stream_byte_i (stream_byte_i),
    .buffer_end_i  (buffer_end_i),
    .head_magic_i  (head_magic_q),
    .tail_magic_i  (tail_magic_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  sxd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_o       (out)
  );

  // Result fields
  assign result_kind_o     = out.kind;
  assign body_byte_o       = out.body_byte;
  assign status_o          = out.status;
  assign route_word_o      = out.route_word;
  assign sequence_number_o = out.sequence_number;
  assign retry_count_o     = out.retry_count;
  assign user_ident_o      = out.user_ident;
  assign session_key_o     = out.session_key;
  assign protocol_word_o   = out.protocol_word;
  assign decoded_length_o  = out.decoded_length;

endmodule
